// ===== hdl/point_to_pixel_projection_assert.svh =====
// Assertion macros shared by the projection checker
`ifndef POINT_TO_PIXEL_PROJECTION_ASSERT_SVH
`define POINT_TO_PIXEL_PROJECTION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("projection check failed");

// condition must never hold
`define PPP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("projection forbidden condition");

`endif

// ===== hdl/ppp_pkg.sv =====
// Shared constants for the point-to-pixel projection block
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_W             = 25;
    localparam int COEF_W              = 32;
    localparam int RANGE_W             = 24;
    localparam int CFG_W               = 64;
    localparam int CFG_IDX_W           = 3;
    localparam int PIX_W               = 16;
    localparam int LEVEL_W             = 8;

    // quotient bits of the dividers, enough to detect 16-bit saturation
    localparam int DIV_QB  = 17;
    localparam int DIV_LAT = DIV_QB + 1;
    // input edge to result strobe, in clock edges
    localparam int PIPE_LAT = 3 + DIV_LAT + 1;

    localparam logic [RANGE_W-1:0] DEPTH_LIMIT_RESET = 24'd5242880;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 3'd6;

endpackage
`default_nettype wire

// ===== hdl/point_to_pixel_projection.sv =====
// Top level: pinhole projection of camera points to pixels with depth color
`timescale 1ns / 1ps
`default_nettype none
// One item enters on any cycle with start high; busy is always low since the
// datapath is fully pipelined at one item per clock. The result is registered
// through 3 multiply/add/prepare stages, 18 stages of the bit-per-stage
// quotient dividers and 1 output stage, the first stage loaded at the
// accepting edge, and is on the ports in the cycle in which done is high; the
// receiver cannot stall, so it must take the result in that cycle. Matrix and
// range registers may be written only while no item is in flight.
module point_to_pixel_projection #(
    parameter int COORD_FRAC_BITS = ppp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [ppp_pkg::COORD_W-1:0]      point_x,
    input  logic signed [ppp_pkg::COORD_W-1:0]      point_y,
    input  logic signed [ppp_pkg::COORD_W-1:0]      point_z,
    output logic                                    done,
    output logic signed [ppp_pkg::PIX_W-1:0]        pixel_u,
    output logic signed [ppp_pkg::PIX_W-1:0]        pixel_v,
    output logic                                    point_valid,
    output logic [ppp_pkg::LEVEL_W-1:0]             green_level,
    output logic [ppp_pkg::LEVEL_W-1:0]             red_blue_level
);
    import ppp_pkg::*;

    localparam int PROD_W = COEF_W + COORD_W;
    localparam int TR_W   = COEF_W + COORD_FRAC_BITS;
    localparam int DOT_W  = ((PROD_W > TR_W) ? PROD_W : TR_W) + 2;
    localparam int NUM_W  = DOT_W + 1;
    localparam int Z100_W = COORD_W + 8;
    localparam int GN_W   = RANGE_W + 16;   // 25500 * z
    localparam int GD_W   = RANGE_W + 9;    // 100 * max depth - one, signed
    localparam int GNUM_W = GN_W + 2;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0]   proj_reg [0:5];
    logic [RANGE_W-1:0] mr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                proj_reg[i] <= '0;
            end
            mr_reg <= DEPTH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0_C01: proj_reg[0] <= cfg_data;
                REG_ROW0_C23: proj_reg[1] <= cfg_data;
                REG_ROW1_C01: proj_reg[2] <= cfg_data;
                REG_ROW1_C23: proj_reg[3] <= cfg_data;
                REG_ROW2_C01: proj_reg[4] <= cfg_data;
                REG_ROW2_C23: proj_reg[5] <= cfg_data;
                REG_DEPTH_LIMIT: mr_reg <= cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: products ----------------
    logic signed [COEF_W-1:0] coef [0:2][0:3];
    logic signed [PROD_W-1:0] prod_reg [0:2][0:2];
    logic signed [COORD_W-1:0] z1_reg;
    logic                      v1_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign coef[r][c] = proj_reg[2*r + c/2][32*(c%2) +: COEF_W];
        end
        always_ff @(posedge clk)
        begin
            prod_reg[r][0] <= coef[r][0] * point_x;
            prod_reg[r][1] <= coef[r][1] * point_y;
            prod_reg[r][2] <= coef[r][2] * point_z;
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg <= point_z;
    end

    // ---------------- stage 2: dot products, depth tests ----------------
    logic signed [DOT_W-1:0]  dot_next [0:2];
    logic signed [DOT_W-1:0]  dot_reg  [0:2];
    logic signed [Z100_W-1:0] z100;
    logic signed [Z100_W-1:0] one_z;
    logic                     zlo_reg;
    logic                     zhi_reg;
    logic [GN_W-1:0]          gn_reg;
    logic signed [GD_W-1:0]   gd_reg;
    logic                     v2_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_dot
        assign dot_next[r] = DOT_W'(prod_reg[r][0]) + DOT_W'(prod_reg[r][1])
                           + DOT_W'(prod_reg[r][2])
                           + (DOT_W'(coef[r][3]) <<< COORD_FRAC_BITS);
        always_ff @(posedge clk)
        begin
            dot_reg[r] <= dot_next[r];
        end
    end

    assign z100  = Z100_W'(z1_reg) * Z100_W'(100);
    assign one_z = Z100_W'(1) <<< COORD_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        zlo_reg <= (z100 >= one_z);
        zhi_reg <= ($signed({1'b0, mr_reg}) >= z1_reg);
        gn_reg  <= GN_W'(z1_reg[RANGE_W-1:0]) * GN_W'(25500);
        gd_reg  <= $signed({{(GD_W-RANGE_W){1'b0}}, mr_reg}) * GD_W'(100)
                 - (GD_W'(1) <<< COORD_FRAC_BITS);
    end

    // ---------------- stage 3: divider operands ----------------
    logic [NUM_W-1:0]  unum_reg, vnum_reg, wden_reg;
    logic [GNUM_W-1:0] gnum_reg, gden_reg;
    logic              wpos_reg, negu_reg, negv_reg, pv3_reg, v3_reg;
    logic [DOT_W-1:0]  au, av;
    logic              wpos;

    assign au   = dot_reg[0][DOT_W-1] ? DOT_W'(-dot_reg[0]) : DOT_W'(dot_reg[0]);
    assign av   = dot_reg[1][DOT_W-1] ? DOT_W'(-dot_reg[1]) : DOT_W'(dot_reg[1]);
    assign wpos = !dot_reg[2][DOT_W-1] && (dot_reg[2] != '0);

    always_ff @(posedge clk)
    begin
        unum_reg <= {au, 1'b0} + NUM_W'(dot_reg[2]);
        vnum_reg <= {av, 1'b0} + NUM_W'(dot_reg[2]);
        wden_reg <= {dot_reg[2], 1'b0};
        gnum_reg <= {1'b0, gn_reg, 1'b0} + GNUM_W'(gd_reg[GD_W-2:0]);
        gden_reg <= GNUM_W'({gd_reg[GD_W-2:0], 1'b0});
        wpos_reg <= wpos;
        negu_reg <= dot_reg[0][DOT_W-1];
        negv_reg <= dot_reg[1][DOT_W-1];
        pv3_reg  <= wpos && zlo_reg && zhi_reg;
    end

    // ---------------- dividers ----------------
    logic [DIV_QB-1:0] qu, qv, qg;

    ppp_div #(.NW(NUM_W), .QB(DIV_QB)) u_div_u (
        .clk (clk), .num (unum_reg), .den (wden_reg), .quo (qu)
    );
    ppp_div #(.NW(NUM_W), .QB(DIV_QB)) u_div_v (
        .clk (clk), .num (vnum_reg), .den (wden_reg), .quo (qv)
    );
    ppp_div #(.NW(GNUM_W), .QB(DIV_QB)) u_div_g (
        .clk (clk), .num (gnum_reg), .den (gden_reg), .quo (qg)
    );

    // sideband flags alongside the dividers
    logic [3:0] sb_reg [0:DIV_LAT-1];
    logic       vd_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= {wpos_reg, negu_reg, negv_reg, pv3_reg};
        for (int i = 1; i < DIV_LAT; i++)
        begin
            sb_reg[i] <= sb_reg[i-1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            done <= vd_reg[DIV_LAT-1];
        end
    end

    // ---------------- output stage ----------------
    logic              o_wpos, o_negu, o_negv, o_pv;
    logic [PIX_W-1:0]  pu_next, pv_next;
    logic [LEVEL_W-1:0] g_next;

    assign {o_wpos, o_negu, o_negv, o_pv} = sb_reg[DIV_LAT-1];

    function automatic logic [PIX_W-1:0] pix_sat(input logic neg,
                                                 input logic [DIV_QB-1:0] q);
        logic [PIX_W-1:0] r;
        if (neg)
        begin
            r = (q > DIV_QB'(32768)) ? 16'h8000 : PIX_W'(-q);
        end
        else
        begin
            r = (q > DIV_QB'(32767)) ? 16'h7FFF : q[PIX_W-1:0];
        end
        return r;
    endfunction

    assign pu_next = o_wpos ? pix_sat(o_negu, qu) : '0;
    assign pv_next = o_wpos ? pix_sat(o_negv, qv) : '0;
    assign g_next  = !o_pv ? '0
                   : ((qg > DIV_QB'(255)) ? 8'hFF : qg[LEVEL_W-1:0]);

    always_ff @(posedge clk)
    begin
        pixel_u        <= pu_next;
        pixel_v        <= pv_next;
        point_valid    <= o_pv;
        green_level    <= g_next;
        red_blue_level <= o_pv ? (8'hFF - g_next) : '0;
    end

endmodule
`default_nettype wire

// ===== hdl/ppp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
`default_nettype none
module ppp_div #(
    parameter int NW = 60,
    parameter int QB = 17
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic [QB-1:0] quo
);
    localparam int RW = NW + QB;

    logic [RW-1:0] rem_reg [0:QB-1];
    logic [NW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];

    // overflow when num >= den * 2^QB (also catches a zero divisor)
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= RW'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= ({den, {QB{1'b0}}} <= RW'(num));
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_stage
        localparam int B = QB - 1 - i;
        logic [RW-1:0] trial;
        logic          take;
        logic [QB-1:0] q_next;

        assign trial = RW'(den_reg[i]) << B;
        assign take  = (rem_reg[i] >= trial);

        always_comb
        begin
            q_next    = q_reg[i];
            q_next[B] = take;
        end

        always_ff @(posedge clk)
        begin
            q_reg[i+1]   <= q_next;
            ovf_reg[i+1] <= ovf_reg[i];
        end

        if (i < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= take ? (rem_reg[i] - trial) : rem_reg[i];
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quo = ovf_reg[QB] ? {QB{1'b1}} : q_reg[QB];

endmodule
`default_nettype wire

// ===== hdl/ppp_checker.sv =====
// Port-level checker for the projection block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "point_to_pixel_projection_assert.svh"
module ppp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic                                point_valid,
    input logic [ppp_pkg::LEVEL_W-1:0]         green_level,
    input logic [ppp_pkg::LEVEL_W-1:0]         red_blue_level
);
    import ppp_pkg::*;

    `PPP_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)
    `PPP_ASSERT_IMPLY(a_done_lat, clk, rst_n, done, $past(start && !busy, PIPE_LAT))
    `PPP_ASSERT_IMPLY(a_levels_sum, clk, rst_n, done && point_valid, 9'(green_level) + 9'(red_blue_level) == 9'd255)
    `PPP_ASSERT_IMPLY(a_invalid_dark, clk, rst_n, done && !point_valid, green_level == '0 && red_blue_level == '0)

endmodule

bind point_to_pixel_projection ppp_checker u_ppp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .point_valid    (point_valid),
    .green_level    (green_level),
    .red_blue_level (red_blue_level)
);
`default_nettype wire

// ===== verif/point_to_pixel_projection_test.sv =====
// Self-checking testbench for the point-to-pixel projection block
`timescale 1ns / 1ps
module point_to_pixel_projection_test;
    import ppp_pkg::*;

    localparam int FRAC = COORD_FRAC_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct {
        logic signed [PIX_W-1:0] u;
        logic signed [PIX_W-1:0] v;
        logic                    ok;
        logic [LEVEL_W-1:0]      green;
        logic [LEVEL_W-1:0]      rb;
    } pixel_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        start;
    logic                        busy;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   point_z;
    logic                        done;
    logic signed [PIX_W-1:0]     pixel_u;
    logic signed [PIX_W-1:0]     pixel_v;
    logic                        point_valid;
    logic [LEVEL_W-1:0]          green_level;
    logic [LEVEL_W-1:0]          red_blue_level;

    point_to_pixel_projection dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .done(done), .pixel_u(pixel_u), .pixel_v(pixel_v),
        .point_valid(point_valid), .green_level(green_level),
        .red_blue_level(red_blue_level)
    );

    // shadow of the block's registers
    logic [CFG_W-1:0]   proj_mat [6];
    logic [RANGE_W-1:0] range_max;

    point_t pending_points [$];
    pixel_t expected_pixels [$];
    point_t cur_point;
    int     idle_pct;
    bit     hold;
    int     sent;
    int     got;
    int     errors;
    int     valid_seen;
    int     idle_cnt;

    function automatic longint coef(int row, int col);
        logic [CFG_W-1:0] r;
        r = proj_mat[row * 2 + col / 2];
        return longint'($signed(r[32 * (col % 2) +: 32]));
    endfunction

    function automatic longint row_dot(int row, longint x, longint y, longint z);
        return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * z
             + coef(row, 3) * (longint'(1) << FRAC);
    endfunction

    // round half away from zero, saturate to 16 bits; den > 0
    function automatic logic [PIX_W-1:0] div_sat(longint num, longint den);
        bit neg;
        longint unsigned a;
        longint unsigned d;
        longint unsigned q;
        neg = num < 0;
        a = neg ? longint'(-num) : num;
        d = den;
        q = (2 * a + d) / (2 * d);
        if (neg)
            return (q > 32768) ? 16'h8000 : 16'(longint'(0) - longint'(q));
        return (q > 32767) ? 16'h7fff : q[PIX_W-1:0];
    endfunction

    function automatic pixel_t project(point_t p);
        pixel_t r;
        longint x, y, z, uu, vv, ww, one, mr, den;
        longint unsigned n, d, q;
        x = p.x;
        y = p.y;
        z = p.z;
        one = longint'(1) << FRAC;
        mr = range_max;
        uu = row_dot(0, x, y, z);
        vv = row_dot(1, x, y, z);
        ww = row_dot(2, x, y, z);
        r.u = 0;
        r.v = 0;
        r.green = 0;
        r.rb = 0;
        if (ww > 0) begin
            r.u = div_sat(uu, ww);
            r.v = div_sat(vv, ww);
        end
        r.ok = (ww > 0) && (z * 100 >= one) && (z <= mr);
        if (r.ok) begin
            den = mr * 100 - one;
            if (den <= 0)
                r.green = 8'd255;
            else begin
                n = z * 25500;
                d = den;
                q = (2 * n + d) / (2 * d);
                r.green = (q > 255) ? 8'd255 : q[7:0];
            end
            r.rb = 8'd255 - r.green;
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_v, act_v);
            errors++;
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n)
            start <= 1'b0;
        else begin
            if (start && !busy)
                expected_pixels.push_back(project(cur_point));
            if (!start || !busy) begin
                if (pending_points.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
                    cur_point = pending_points.pop_front();
                    sent++;
                    start   <= 1'b1;
                    point_x <= cur_point.x;
                    point_y <= cur_point.y;
                    point_z <= cur_point.z;
                end else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        pixel_t e;
        if (rst_n && done) begin
            got++;
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: result with no item pending, actual u %0d v %0d", $time,
                         pixel_u, pixel_v);
                errors++;
            end else begin
                e = expected_pixels.pop_front();
                check_field("pixel_u", e.u, pixel_u);
                check_field("pixel_v", e.v, pixel_v);
                check_field("point_valid", e.ok, point_valid);
                check_field("green_level", e.green, green_level);
                check_field("red_blue_level", e.rb, red_blue_level);
                if (point_valid)
                    valid_seen++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cnt <= 0;
        else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t ns: no activity for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < 6)
            proj_mat[idx] = val;
        else if (idx == REG_DEPTH_LIMIT)
            range_max = val[RANGE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (pending_points.size() > 0 || got != sent)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // plausible camera matrix with random focal, center and translation
    task automatic load_camera();
        logic [31:0] fx, fy, cx, cy, tx, ty, tz, one_c;
        fx = (32'd600 + $urandom_range(200)) << 16 | $urandom_range(16'hffff);
        fy = (32'd600 + $urandom_range(200)) << 16 | $urandom_range(16'hffff);
        cx = (32'd500 + $urandom_range(200)) << 16;
        cy = (32'd150 + $urandom_range(100)) << 16;
        tx = $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
        ty = $urandom_range(32'h0000_ffff) - 32'h0000_8000;
        tz = $urandom_range(32'h0000_1fff);
        one_c = 32'h0001_0000;
        cfg_write(REG_ROW0_C01, {32'd0, fx});
        cfg_write(REG_ROW0_C23, {tx, cx});
        cfg_write(REG_ROW1_C01, {fy, 32'd0});
        cfg_write(REG_ROW1_C23, {ty, cy});
        cfg_write(REG_ROW2_C01, 64'd0);
        cfg_write(REG_ROW2_C23, {tz, one_c});
    endtask

    function automatic point_t mk(longint x, longint y, longint z);
        point_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.z = z[COORD_W-1:0];
        return p;
    endfunction

    // mostly points in front of the camera; some raw noise
    task automatic push_random(int count);
        point_t p;
        longint z, span;
        repeat (count) begin
            if ($urandom_range(9) < 3) begin
                p.x = COORD_W'($urandom);
                p.y = COORD_W'($urandom);
                p.z = COORD_W'($urandom);
            end else begin
                case ($urandom_range(9))
                    0: z = 640 + $urandom_range(40);
                    1: z = longint'(range_max) - 8 + $urandom_range(16);
                    default: z = $urandom_range(range_max + 2000);
                endcase
                if (z > 24'hff_ffff)
                    z = 24'hff_ffff;
                span = z / 2 + 1;
                p = mk(longint'($urandom_range(32'(2 * span))) - span,
                       longint'($urandom_range(32'(2 * span))) - span / 4, z);
            end
            pending_points.push_back(p);
        end
    endtask

    task automatic push_directed();
        longint mx, mn, mr;
        mx = 24'hff_ffff;
        mn = -(longint'(1) << 24);
        mr = range_max;
        pending_points.push_back(mk(0, 0, 0));
        pending_points.push_back(mk(mx, mx, mx));
        pending_points.push_back(mk(mn, mn, mn));
        pending_points.push_back(mk(0, 0, 655));         // just below 0.01 m
        pending_points.push_back(mk(0, 0, 656));         // lowest valid depth
        pending_points.push_back(mk(1000, -1000, mr));   // at the far limit
        pending_points.push_back(mk(1000, -1000, mr + 1));
        pending_points.push_back(mk(0, 0, -65536));      // behind the camera
        pending_points.push_back(mk(mn, 0, 65536));
        pending_points.push_back(mk(mx, 0, 65536));
        pending_points.push_back(mk(0, mn, 65536));
        pending_points.push_back(mk(0, mx, 65536));
        pending_points.push_back(mk(65536, 65536, 1 << 20));
        pending_points.push_back(mk(mx, mn, 1));          // tiny w, saturates
        pending_points.push_back(mk(-5000, 7000, -1));
        pending_points.push_back(mk(123456, -654321, mr / 2));
        pending_points.push_back(mk(0, 0, mx));
        pending_points.push_back(mk(mn, mx, mr - 1));
    endtask

    initial begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        cur_point = mk(0, 0, 0);
        idle_pct = 0;
        hold = 1'b0;
        sent = 0;
        got = 0;
        errors = 0;
        valid_seen = 0;
        for (int i = 0; i < 6; i++)
            proj_mat[i] = '0;
        range_max = DEPTH_LIMIT_RESET;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // matrix at reset value: w is zero everywhere
        push_directed();
        settle();

        // camera matrix, default range
        load_camera();
        cfg_write(REG_UNUSED, {64{1'b1}});     // ignored index
        push_directed();
        push_random(250);
        settle();

        // new camera, random range, sender idling
        load_camera();
        cfg_write(REG_DEPTH_LIMIT, 64'($urandom_range(24'hff_ffff)));
        idle_pct = 62;
        push_random(200);
        settle();

        // fully random matrix, widest range
        for (int i = 0; i < 6; i++)
            cfg_write(i[CFG_IDX_W-1:0], {$urandom, $urandom});
        cfg_write(REG_DEPTH_LIMIT, 64'hff_ffff);
        idle_pct = 23;
        push_directed();
        push_random(150);
        settle();

        // extreme coefficients, smallest range with positive divisor
        for (int i = 0; i < 6; i++)
            cfg_write(i[CFG_IDX_W-1:0], (i % 2) ? {32'h8000_0000, 32'h7fff_ffff}
                                                : {32'h7fff_ffff, 32'h8000_0000});
        cfg_write(REG_DEPTH_LIMIT, 64'd656);
        idle_pct = 62;
        push_random(100);
        settle();

        // zero range; sender holds off mid-phase until the pipe drains
        load_camera();
        cfg_write(REG_DEPTH_LIMIT, 64'd0);
        idle_pct = 0;
        push_random(50);
        while (pending_points.size() > 0)
            @(posedge clk);
        hold = 1'b1;
        while (got != sent)
            @(posedge clk);
        hold = 1'b0;
        push_random(50);
        settle();

        // range whose divisor is negative
        cfg_write(REG_ROW2_C23, {32'h0000_0100, 32'h0001_0000});
        cfg_write(REG_DEPTH_LIMIT, 64'd655);
        idle_pct = 23;
        push_random(100);
        settle();

        $display("Projected %0d points over 7 register settings, %0d valid in range,",
                 got, valid_seen);
        $display("with sender idling at 0, 23 and 62 percent and one full drain.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
